// File: rtl/sbq_pkg.sv
// Shared types and constants for the shelving biquad filter.
`default_nettype none

package sbq_pkg;

  // Coefficient format: signed Q7.24 held in 32 bits
  localparam int COEF_W     = 32;
  localparam int CH_FIELD_W = 3;
  localparam int REG_IDX_W  = 3;

  // Register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_FF0 = 3'd0,
    REG_COEF_FF1 = 3'd1,
    REG_COEF_FF2 = 3'd2,
    REG_COEF_FB1 = 3'd3,
    REG_COEF_FB2 = 3'd4,
    REG_BYPASS   = 3'd5
  } cfg_reg_e;

  // Unity gain in Q7.24
  localparam logic signed [COEF_W-1:0] COEF_FF0_RST = 32'sd16777216;

  typedef struct packed {
    logic signed [COEF_W-1:0] ff0;
    logic signed [COEF_W-1:0] ff1;
    logic signed [COEF_W-1:0] ff2;
    logic signed [COEF_W-1:0] fb1;
    logic signed [COEF_W-1:0] fb2;
  } coef_set_t;

  typedef struct packed {
    coef_set_t coef;
    logic      bypass;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/sbq_stream_if.sv
// Valid/ready stream interfaces for input samples and filtered samples.
`default_nettype none

interface sbq_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [2:0]                    channel;
  logic                          last_in_frame;

  modport source (output valid, in_sample, channel, last_in_frame, input ready);
  modport sink   (input valid, in_sample, channel, last_in_frame, output ready);
endinterface

interface sbq_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic [2:0]                    out_channel;
  logic                          out_last;

  modport source (output valid, out_sample, out_channel, out_last, input ready);
  modport sink   (input valid, out_sample, out_channel, out_last, output ready);
endinterface

`default_nettype wire

// File: rtl/shelf_biquad_filter.sv
// Path: an accepted sample waits in stage 1 for its history read, has its products
//   registered in stage 2, and is presented from the output register.
// Throughput: one sample per cycle across channels unless the output stalls; a sample
//   of a channel still being updated ahead waits, set by the multiply-and-sum history loop.
// The output register lets a new sample enter while a finished one waits to be taken.
// Reset: coefficients go to unity pass-through with bypass set; history valid bits
//   clear at once, so every channel restarts from zero history without a clearing pass.
`default_nettype none

module shelf_biquad_filter
  import sbq_pkg::*;
#(
  parameter int CHANNELS       = 8,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  sbq_in_if.sink                    in_i,
  sbq_out_if.source                 out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COEF_W-1:0]    cfg_data_i
);

  localparam int SB      = SAMPLE_BITS;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W = 4 * SB;

  cfg_t cfg;

  // Handshake and hazard control
  logic in_acc, in_range, in_filt, hazard;
  logic out_free, s2_adv, s2_free, s1_adv, s1_free;
  logic [CH_W+CH_FIELD_W-1:0] in_ch_ext, s2_ch_ext;
  logic [CH_W-1:0] in_idx, s2_idx;

  // Stage 1: history read in flight
  logic                   s1_vld_q, s1_filt_q, s1_last_q, s1_fwd_q;
  logic [CH_FIELD_W-1:0]  s1_ch_q;
  logic signed [SB-1:0]   s1_x_q;
  logic [ENTRY_W-1:0]     s1_fwdd_q, s1_hist, mem_rd;

  // Stage 2: products registered
  logic                   s2_vld_q, s2_filt_q, s2_last_q;
  logic [CH_FIELD_W-1:0]  s2_ch_q;
  logic signed [SB-1:0]   s2_x_q, s2_x1_q, s2_y1_q, y;
  logic                   wr_en;
  logic [ENTRY_W-1:0]     wr_data;

  // Output register
  logic                   out_vld_q, out_last_q;
  logic [CH_FIELD_W-1:0]  out_ch_q;
  logic signed [SB-1:0]   out_sample_q;

  sbq_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Channel range check and memory index
  always_comb begin
    in_range  = (32'(in_i.channel) < CHANNELS);
    in_filt   = !cfg.bypass && in_range;
    in_ch_ext = {{CH_W{1'b0}}, in_i.channel};
    in_idx    = in_ch_ext[CH_W-1:0];
    s2_ch_ext = {{CH_W{1'b0}}, s2_ch_q};
    s2_idx    = s2_ch_ext[CH_W-1:0];
  end

  // Advance stages; stall a sample whose channel is still being updated ahead
  always_comb begin
    out_free = !out_vld_q || out_o.ready;
    s2_adv   = s2_vld_q && out_free;
    s2_free  = !s2_vld_q || s2_adv;
    s1_adv   = s1_vld_q && s2_free;
    s1_free  = !s1_vld_q || s1_adv;
    hazard   = in_filt &&
               ((s1_vld_q && s1_filt_q && (s1_ch_q == in_i.channel)) ||
                (s2_vld_q && s2_filt_q && (s2_ch_q == in_i.channel) && !s2_adv));
  end

  assign in_i.ready = s1_free && !hazard;
  assign in_acc     = in_i.valid && in_i.ready;

  // History write-back from stage 2
  assign wr_en   = s2_adv && s2_filt_q;
  assign wr_data = {s2_x_q, s2_x1_q, y, s2_y1_q};

  sbq_hist_mem #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc && in_filt),
    .rd_idx_i  (in_idx),
    .rd_data_o (mem_rd),
    .wr_en_i   (wr_en),
    .wr_idx_i  (s2_idx),
    .wr_data_i (wr_data)
  );

  // Use forwarded history when the write landed on the read edge
  assign s1_hist = s1_fwd_q ? s1_fwdd_q : mem_rd;

  sbq_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .en_i   (s1_adv),
    .x_i    (s1_x_q),
    .hist_i (s1_hist),
    .coef_i (cfg.coef),
    .y_o    (y)
  );

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_q <= in_acc;
      end
      if (s2_free) begin
        s2_vld_q <= s1_adv;
      end
      if (out_free) begin
        out_vld_q <= s2_adv;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_filt_q <= in_filt;
      s1_ch_q   <= in_i.channel;
      s1_last_q <= in_i.last_in_frame;
      s1_x_q    <= in_i.in_sample;
      s1_fwd_q  <= wr_en && (s2_ch_q == in_i.channel);
      s1_fwdd_q <= wr_data;
    end
    if (s1_adv) begin
      s2_filt_q <= s1_filt_q;
      s2_ch_q   <= s1_ch_q;
      s2_last_q <= s1_last_q;
      s2_x_q    <= s1_x_q;
      s2_x1_q   <= $signed(s1_hist[4*SB-1:3*SB]);
      s2_y1_q   <= $signed(s1_hist[2*SB-1:SB]);
    end
    if (s2_adv) begin
      out_sample_q <= s2_filt_q ? y : s2_x_q;
      out_ch_q     <= s2_ch_q;
      out_last_q   <= s2_last_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_sample  = out_sample_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.out_last    = out_last_q;

endmodule

`default_nettype wire

// File: rtl/sbq_cfg_regs.sv
// Configuration register file: coefficients and bypass flag.
`default_nettype none

module sbq_cfg_regs
  import sbq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COEF_W-1:0]    cfg_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q;

  // Decode the write index; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef.ff0 <= COEF_FF0_RST;
      cfg_q.coef.ff1 <= '0;
      cfg_q.coef.ff2 <= '0;
      cfg_q.coef.fb1 <= '0;
      cfg_q.coef.fb2 <= '0;
      cfg_q.bypass   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COEF_FF0: cfg_q.coef.ff0 <= $signed(cfg_data_i);
        REG_COEF_FF1: cfg_q.coef.ff1 <= $signed(cfg_data_i);
        REG_COEF_FF2: cfg_q.coef.ff2 <= $signed(cfg_data_i);
        REG_COEF_FB1: cfg_q.coef.fb1 <= $signed(cfg_data_i);
        REG_COEF_FB2: cfg_q.coef.fb2 <= $signed(cfg_data_i);
        REG_BYPASS:   cfg_q.bypass   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/sbq_hist_mem.sv
// Per-channel history memory with registered read data and reset-cleared valid bits.
`default_nettype none

module sbq_hist_mem #(
  parameter int  CHANNELS    = 8,
  parameter int  SAMPLE_BITS = 24,
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int ENTRY_W     = 4 * SAMPLE_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [CH_W-1:0]          rd_idx_i,
  output logic      [ENTRY_W-1:0]       rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [CH_W-1:0]          wr_idx_i,
  input  wire logic [ENTRY_W-1:0]       wr_data_i
);

  logic [ENTRY_W-1:0]  mem_q [CHANNELS];
  logic [ENTRY_W-1:0]  rdata_q;
  logic [CHANNELS-1:0] valid_q;
  logic                rd_vld_q;

  // Write and read the history array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_idx_i];
    end
  end

  // Track written entries; unwritten entries read as zero history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// File: rtl/sbq_mac.sv
// Five-tap multiply stage and rounding, shifting, saturating sum.
`default_nettype none

module sbq_mac
  import sbq_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   x_i,
  input  wire logic        [4*SAMPLE_BITS-1:0] hist_i,
  input  wire coef_set_t                       coef_i,
  output logic signed      [SAMPLE_BITS-1:0]   y_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int P_W   = COEF_W + SB;
  localparam int SUM_W = P_W + 3;

  localparam logic signed [SUM_W-1:0] RND  = SUM_W'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] SMAX = {{(SUM_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMIN = ~SMAX;

  logic signed [SB-1:0]    x1, x2, y1, y2;
  logic signed [P_W-1:0]   p0_q, p1_q, p2_q, p3_q, p4_q;
  logic signed [SUM_W-1:0] sum, sum_sh;

  assign x1 = $signed(hist_i[4*SB-1:3*SB]);
  assign x2 = $signed(hist_i[3*SB-1:2*SB]);
  assign y1 = $signed(hist_i[2*SB-1:SB]);
  assign y2 = $signed(hist_i[SB-1:0]);

  // Register the five products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= coef_i.ff0 * x_i;
      p1_q <= coef_i.ff1 * x1;
      p2_q <= coef_i.ff2 * x2;
      p3_q <= coef_i.fb1 * y1;
      p4_q <= coef_i.fb2 * y2;
    end
  end

  // Sum, round half up, drop the fraction and clamp
  always_comb begin
    sum    = SUM_W'(p0_q) + SUM_W'(p1_q) + SUM_W'(p2_q)
           - SUM_W'(p3_q) - SUM_W'(p4_q) + RND;
    sum_sh = sum >>> COEF_FRAC_BITS;
    if (sum_sh > SMAX) begin
      y_o = SMAX[SB-1:0];
    end else if (sum_sh < SMIN) begin
      y_o = SMIN[SB-1:0];
    end else begin
      y_o = sum_sh[SB-1:0];
    end
  end

endmodule

`default_nettype wire

// File: dv/shelf_biquad_checker.sv
// Scoreboard for the shelving biquad filter: predicts every result and compares it.
`default_nettype none

module shelf_biquad_checker
  import sbq_pkg::*;
#(
  parameter int CHANNELS       = 8,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  sbq_in_if                         in_mon,
  sbq_out_if                        out_mon,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COEF_W-1:0]    cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam int     MAX_REPORTS = 10;
  localparam longint SAT_HI      = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO      = -(longint'(1) <<< (SAMPLE_BITS - 1));
  localparam longint ROUND_HALF  = longint'(1) <<< (COEF_FRAC_BITS - 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CH_FIELD_W-1:0]         channel;
    logic                          last;
  } filt_result_t;

  // Mirror of the register file and the per-channel history
  coef_set_t                     gain;
  logic                          bypass_q;
  logic signed [SAMPLE_BITS-1:0] x_one [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x_two [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y_one [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y_two [CHANNELS];

  filt_result_t expected_q [$];
  filt_result_t want;
  filt_result_t got;
  logic signed [SAMPLE_BITS-1:0] y_new;
  int fails;

  // Exact direct-form-I sum, round half up, shift, then clamp to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] shelf_output(
    input logic signed [SAMPLE_BITS-1:0] x,
    input logic [CH_FIELD_W-1:0]         ch
  );
    longint acc;
    longint y_full;
    acc = longint'($signed(gain.ff0)) * longint'(x)
        + longint'($signed(gain.ff1)) * longint'(x_one[ch])
        + longint'($signed(gain.ff2)) * longint'(x_two[ch])
        - longint'($signed(gain.fb1)) * longint'(y_one[ch])
        - longint'($signed(gain.fb2)) * longint'(y_two[ch]);
    y_full = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
    if (y_full > SAT_HI) y_full = SAT_HI;
    if (y_full < SAT_LO) y_full = SAT_LO;
    return y_full[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain.ff0 = COEF_FF0_RST;
      gain.ff1 = '0;
      gain.ff2 = '0;
      gain.fb1 = '0;
      gain.fb2 = '0;
      bypass_q = 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
        x_one[c] = '0;
        x_two[c] = '0;
        y_one[c] = '0;
        y_two[c] = '0;
      end
      expected_q.delete();
      fails = 0;
    end else begin
      // Track register writes; spare indexes are dropped
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_COEF_FF0: gain.ff0 = cfg_data_i;
          REG_COEF_FF1: gain.ff1 = cfg_data_i;
          REG_COEF_FF2: gain.ff2 = cfg_data_i;
          REG_COEF_FB1: gain.fb1 = cfg_data_i;
          REG_COEF_FB2: gain.fb2 = cfg_data_i;
          REG_BYPASS:   bypass_q = cfg_data_i[0];
          default: ;
        endcase
      end

      // Compare each output transaction with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got.sample  = out_mon.out_sample;
        got.channel = out_mon.out_channel;
        got.last    = out_mon.out_last;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("unexpected result: sample %0d channel %0d last %0b",
                     got.sample, got.channel, got.last);
        end else begin
          want = expected_q.pop_front();
          if (got.sample !== want.sample || got.channel !== want.channel ||
              got.last !== want.last) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("mismatch: expected sample %0d ch %0d last %0b, got %0d ch %0d last %0b",
                       want.sample, want.channel, want.last,
                       got.sample, got.channel, got.last);
          end
        end
      end

      // Predict the result of each input transaction and advance the history of filtered ones
      if (in_mon.valid && in_mon.ready) begin
        want.channel = in_mon.channel;
        want.last    = in_mon.last_in_frame;
        if (bypass_q || int'(in_mon.channel) >= CHANNELS) begin
          want.sample = in_mon.in_sample;
        end else begin
          y_new = shelf_output(in_mon.in_sample, in_mon.channel);
          want.sample = y_new;
          x_two[in_mon.channel] = x_one[in_mon.channel];
          x_one[in_mon.channel] = in_mon.in_sample;
          y_two[in_mon.channel] = y_one[in_mon.channel];
          y_one[in_mon.channel] = y_new;
        end
        expected_q.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
  end

endmodule

`default_nettype wire

// File: dv/shelf_biquad_filter_tb.sv
// Stimulus and verdict for the shelving biquad filter: directed cases, then random phases.
`default_nettype none

module shelf_biquad_filter_tb;
  import sbq_pkg::*;

  localparam int CHANNELS       = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 24;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 300;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 250;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;
  localparam logic [COEF_W-1:0] C_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] C_MIN  = 32'h8000_0000;
  localparam logic [COEF_W-1:0] C_HALF = 32'h0080_0000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0]    cfg_data;
  int                   fail_count;
  int                   pending;
  int                   cycle_cnt = 0;
  logic                 hold_req  = 1'b0;
  logic                 hold_done = 1'b0;

  sbq_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_in  ();
  sbq_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_out ();

  shelf_biquad_filter #(
    .CHANNELS      (CHANNELS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (smp_in),
    .out_o     (smp_out),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  shelf_biquad_checker #(
    .CHANNELS      (CHANNELS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (smp_in),
    .out_mon     (smp_out),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // One register write; called at a rising edge, returns at a rising edge
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] ff0, input logic [COEF_W-1:0] ff1,
                            input logic [COEF_W-1:0] ff2, input logic [COEF_W-1:0] fb1,
                            input logic [COEF_W-1:0] fb2, input logic [COEF_W-1:0] byp);
    write_reg(REG_COEF_FF0, ff0);
    write_reg(REG_COEF_FF1, ff1);
    write_reg(REG_COEF_FF2, ff2);
    write_reg(REG_COEF_FB1, fb1);
    write_reg(REG_COEF_FB2, fb2);
    write_reg(REG_BYPASS, byp);
  endtask

  // Offer one sample and hold it until the transaction completes
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s,
                             input logic [CH_FIELD_W-1:0] ch, input logic last);
    smp_in.valid         <= 1'b1;
    smp_in.in_sample     <= s;
    smp_in.channel       <= ch;
    smp_in.last_in_frame <= last;
    @(negedge clk);
    while (!smp_in.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic pause_gap(input int cycles);
    smp_in.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic drain();
    smp_in.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r == 0) return S_MAX;
    if (r == 1) return S_MIN;
    if (r < 4) begin
      v = int'($urandom_range(0, 512)) - 256;
      return v[SAMPLE_BITS-1:0];
    end
    return SAMPLE_BITS'($urandom);
  endfunction

  // Coefficient styles: 0 any value, 1 an end of the range, 2 near unity scale, 3 zero
  function automatic logic [COEF_W-1:0] pick_coef(input int style);
    int v;
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? C_MAX : C_MIN;
      2: begin
        v = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        return v;
      end
      default: return '0;
    endcase
  endfunction

  function automatic int pick_style(input int phase);
    int unsigned r;
    if (phase == 0) return 2;
    if (phase == 1) return 1;
    r = $urandom_range(0, 5);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r == 5) return 3;
    return 2;
  endfunction

  // Receiver: stall pattern of its own, plus one long hold-off on request
  initial begin
    int mode;
    int stretch;
    int k;
    smp_out.ready <= 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(4, 60);
      for (k = 0; k < stretch; k++) begin
        @(posedge clk);
        case (mode)
          0:       smp_out.ready <= 1'b1;
          1:       smp_out.ready <= ($urandom_range(0, 3) != 0);
          2:       smp_out.ready <= ($urandom_range(0, 3) == 0);
          default: smp_out.ready <= 1'($urandom_range(0, 1));
        endcase
      end
      if (hold_req && !hold_done) begin
        @(posedge clk);
        smp_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int phase;
    int left;
    int burst;
    int spread;
    logic [COEF_W-1:0] byp_word;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= '0;
    cfg_data             <= '0;
    smp_in.valid         <= 1'b0;
    smp_in.in_sample     <= '0;
    smp_in.channel       <= '0;
    smp_in.last_in_frame <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: bypass passes samples unchanged
    send_sample(S_MAX, 3'd0, 1'b0);
    send_sample(S_MIN, 3'd7, 1'b1);
    send_sample('0, 3'd3, 1'b0);
    send_sample(-24'sd1, 3'd5, 1'b1);
    send_sample(24'sh5A5A5A, 3'd1, 1'b0);
    drain();

    // Only bit 0 of bypass counts; spare indexes are ignored
    write_reg(REG_BYPASS, 32'hFFFF_FFFE);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h0000_0000);
    send_sample(S_MAX, 3'd2, 1'b0);
    send_sample(S_MIN, 3'd2, 1'b1);
    send_sample('0, 3'd6, 1'b0);
    send_sample(-24'sd1, 3'd4, 1'b0);
    drain();

    // Extreme coefficients drive both saturation ends
    load_coefs(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 32'h0);
    send_sample(S_MAX, 3'd1, 1'b0);
    send_sample(S_MIN, 3'd1, 1'b0);
    send_sample(S_MAX, 3'd1, 1'b1);
    send_sample(S_MIN, 3'd6, 1'b0);
    send_sample(24'sd1, 3'd6, 1'b0);
    send_sample(-24'sd1, 3'd1, 1'b1);
    drain();

    // Half gain exercises rounding at exactly one half
    load_coefs(C_HALF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_sample(24'sd1, 3'd0, 1'b0);
    send_sample(-24'sd1, 3'd0, 1'b0);
    send_sample(24'sd3, 3'd0, 1'b0);
    send_sample(-24'sd3, 3'd0, 1'b1);
    drain();

    // Random phases, each under its own register setting
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      byp_word    = $urandom;
      byp_word[0] = (phase == 2) ? 1'b1 : ($urandom_range(0, 5) == 0);
      load_coefs(pick_coef(pick_style(phase)), pick_coef(pick_style(phase)),
                 pick_coef(pick_style(phase)), pick_coef(pick_style(phase)),
                 pick_coef(pick_style(phase)), byp_word);
      spread = $urandom_range(1, CHANNELS);
      if (phase == 3) hold_req <= 1'b1;
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 30);
        if (burst > left) burst = left;
        repeat (burst)
          send_sample(pick_sample(), CH_FIELD_W'($urandom_range(0, spread - 1)),
                      1'($urandom_range(0, 1)));
        left -= burst;
        if ($urandom_range(0, 2) != 0) pause_gap($urandom_range(1, 12));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/sbq_pkg.sv
rtl/sbq_stream_if.sv
rtl/sbq_cfg_regs.sv
rtl/sbq_hist_mem.sv
rtl/sbq_mac.sv
rtl/shelf_biquad_filter.sv
dv/shelf_biquad_checker.sv
dv/shelf_biquad_filter_tb.sv
